// ===== src/abt_pkg.sv =====
// Shared types and constants for the address blocklist table.
// Used by the cell row, the top level and the port checker; no dependencies.
package abt_pkg;

  localparam int ADDR_W      = 32;
  localparam int IDX_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int DEF_ENTRIES = 16;

  // Command codes carried on the cmd port.
  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } abt_cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } abt_status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_APPLY
  } abt_state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              compare;
    logic              commit;
    abt_cmd_e          cmd;
    logic [ADDR_W-1:0] address;
  } abt_ctrl_t;

endpackage

// ===== src/abt_cell.sv =====
// One storage cell of the blocklist row: holds one address and its match flag.
// Depends on abt_pkg for the control struct and command codes.
module abt_cell
  import abt_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int FILL_W = 5
) (
  input  logic              clk,
  input  abt_ctrl_t         ctrl,
  input  logic [FILL_W-1:0] fill,
  input  logic [ADDR_W-1:0] next_entry,
  input  logic              prior_in,
  output logic              prior_out,
  output logic [ADDR_W-1:0] entry
);

  logic match;
  logic valid;

  // The cell is in use when its position is below the fill level.
  assign valid = FILL_W'(IDX) < fill;

  // A match at this cell or any lower one passes up the row.
  assign prior_out = prior_in | match;

  // Match flag is captured in the compare cycle.
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= valid && (entry == ctrl.address);
    end
  end

  // Add writes the cell at the fill position; delete shifts from the upper neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (ctrl.cmd == CMD_ADD && fill == FILL_W'(IDX)) begin
        entry <= ctrl.address;
      end else if (ctrl.cmd == CMD_DELETE && prior_out) begin
        entry <= next_entry;
      end
    end
  end

endmodule

// ===== src/address_blocklist_table.sv =====
// Address blocklist table: a row of address cells plus the command sequencer.
// Depends on abt_pkg and abt_cell.
//
// Usage:
//   The input channel (in_valid, in_ready) carries one command per transfer:
//   cmd, address and index. The output channel (out_valid, out_ready) carries
//   one result per command: hit, status, entry and count.
//   Each command passes through the transfer cycle, a compare cycle in
//   which every cell matches its stored address against the command address
//   at once, and an apply cycle in which the first-match chain through the
//   cells settles, the row is updated and the result is registered. A new
//   command is taken only once the previous one has been applied.
//   The result register decouples the two sides: the next command is taken
//   while a result still waits. If the receiver stalls, the block holds in
//   its apply cycle until the result register is free.
//   A synchronous reset empties the table (the fill count goes to zero) and
//   drops any pending result; stored addresses are not cleared, since only
//   positions below the fill count are ever read.
module address_blocklist_table
  import abt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [ADDR_W-1:0]  address,
  input  logic [IDX_W-1:0]   index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  entry,
  output logic [COUNT_W-1:0] count
);

  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;
  localparam int RD_N   = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);

  abt_state_e        state, state_next;
  abt_cmd_e          cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [FILL_W-1:0] fill, fill_next;
  abt_ctrl_t         ctrl;

  logic [ADDR_W-1:0] cell_entry [ENTRIES];
  logic [ENTRIES:0]  prior;

  logic              found;
  logic              full;
  logic              out_range;
  logic [ADDR_W-1:0] rd_data;
  logic              load;

  logic              res_hit;
  abt_status_e       res_status;
  logic [ADDR_W-1:0] res_entry;

  // Row of cells; the first-match chain runs from position zero upward.
  assign prior[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0] upper;
    if (i == ENTRIES - 1) begin : g_top
      assign upper = cell_entry[i];
    end else begin : g_mid
      assign upper = cell_entry[i+1];
    end
    abt_cell #(
      .IDX    (i),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .fill       (fill),
      .next_entry (upper),
      .prior_in   (prior[i]),
      .prior_out  (prior[i+1]),
      .entry      (cell_entry[i])
    );
  end

  assign found = prior[ENTRIES];
  assign full  = fill == FILL_W'(ENTRIES);
  assign out_range = CMP_W'(idx_r) >= CMP_W'(fill);

  // Read select over the positions the index can reach.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (idx_r == IDX_W'(k)) begin
        rd_data = cell_entry[k];
      end
    end
  end

  // Result and new fill level for the command in hand.
  always_comb begin
    res_hit    = 1'b0;
    res_status = ST_OK;
    res_entry  = '0;
    fill_next  = fill;
    case (cmd_r)
      CMD_CHECK: begin
        res_hit = found;
      end
      CMD_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          fill_next = fill + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (found) begin
          res_hit   = 1'b1;
          fill_next = fill - 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (out_range) begin
          res_status = ST_RANGE;
        end else begin
          res_entry = rd_data;
        end
      end
    endcase
  end

  // Sequencer: next state and control strobes.
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    load         = 1'b0;
    ctrl.compare = 1'b0;
    ctrl.commit  = 1'b0;
    ctrl.cmd     = cmd_r;
    ctrl.address = addr_r;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        ctrl.compare = 1'b1;
        state_next   = S_APPLY;
      end
      S_APPLY: begin
        if (!out_valid || out_ready) begin
          load        = 1'b1;
          ctrl.commit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, fill level and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture at the input transfer.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= abt_cmd_e'(cmd);
      addr_r <= address;
      idx_r  <= index;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      hit    <= res_hit;
      status <= res_status;
      entry  <= res_entry;
      count  <= COUNT_W'(fill_next);
    end
  end

endmodule

// ===== src/abt_checker.sv =====
// Port-level checker for the address blocklist table, bound to the top level.
// Depends on abt_pkg for the status codes.
module abt_checker
  import abt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic [1:0]         status,
  input logic [ADDR_W-1:0]  entry,
  input logic [COUNT_W-1:0] count
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still valid after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry) && $stable(count)
      && $stable(status) && $stable(hit))
    else $error("stalled result changed");

  // A hit is only reported with an ok status.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_OK)
    else $error("hit with error status");

  // Anything but a successful read carries a zero entry; checked for error results and hits.
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK || hit) |-> entry == '0)
    else $error("entry nonzero outside a read");

  // A full report shows the table capacity as its count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == COUNT_W'(ENTRIES))
    else $error("table full with wrong count");

endmodule

bind address_blocklist_table abt_checker #(
  .ENTRIES (ENTRIES)
) u_abt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .status    (status),
  .entry     (entry),
  .count     (count)
);
